>>> rtl/core/ypid_pkg.sv
// ----------------------------------------------------------------------------
// ypid_pkg
// Shared types and constants of the yaw PID controller: field widths, turn
// constants, register map, configuration struct and controller/datapath links.
// ----------------------------------------------------------------------------
package ypid_pkg;

    localparam int ANGLE_W   = 16;
    localparam int DIFF_W    = 18;
    localparam int ERR_W     = 17;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 24;
    localparam int BAND_W    = 15;
    localparam int DEAD_W    = 23;
    localparam int RPM_W     = 16;
    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = 12;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // heading turn constants in 0.01 degree
    localparam logic signed [DIFF_W-1:0] HALF_TURN       = 18'sd18000;
    localparam logic signed [DIFF_W-1:0] FULL_TURN       = 18'sd36000;
    localparam logic signed [DIFF_W-1:0] THREE_HALF_TURN = 18'sd54000;
    localparam logic signed [DIFF_W-1:0] TWO_TURNS       = 18'sd72000;

    // rounding offset for truncation toward zero of 1/256 rpm to rpm
    localparam logic signed [LIMIT_W-1:0] RPM_ROUND = 24'sd255;

    // register indexes
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_OUTPUT_LOW    = 3'd3;
    localparam logic [2:0] REG_OUTPUT_HIGH   = 3'd4;
    localparam logic [2:0] REG_INTEG_BAND    = 3'd5;
    localparam logic [2:0] REG_ARRIVAL_TOL   = 3'd6;
    localparam logic [2:0] REG_ARRIVAL_DEAD  = 3'd7;

    // register reset values
    localparam logic signed [LIMIT_W-1:0] OUTPUT_LOW_RST  = -24'sd25600;
    localparam logic signed [LIMIT_W-1:0] OUTPUT_HIGH_RST = 24'sd25600;
    localparam logic [BAND_W-1:0]         INTEG_BAND_RST  = 15'd18000;
    localparam logic [BAND_W-1:0]         ARRIVAL_TOL_RST = 15'd100;
    localparam logic [DEAD_W-1:0]         ARRIVAL_DEAD_RST = 23'd256;

    typedef struct packed {
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         integral_gain;
        logic [GAIN_W-1:0]         deriv_gain;
        logic signed [LIMIT_W-1:0] output_low;
        logic signed [LIMIT_W-1:0] output_high;
        logic [BAND_W-1:0]         integration_band;
        logic [BAND_W-1:0]         arrival_tolerance;
        logic [DEAD_W-1:0]         arrival_deadband;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic idle;
        logic wrap;
        logic integ;
        logic mul;
        logic clamp;
        logic excess;
        logic div;
        logic back;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic taken;
        logic run;
        logic mul_last;
        logic need_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/ypid_if.sv
// ----------------------------------------------------------------------------
// ypid_if
// Valid/ready channels of the yaw PID controller: tick input and result.
// ----------------------------------------------------------------------------
interface ypid_in_if import ypid_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic                        run;
    logic signed [ANGLE_W-1:0]   target_angle;
    logic signed [ANGLE_W-1:0]   measured_angle;

    modport source (output valid, run, target_angle, measured_angle, input ready);
    modport sink   (input valid, run, target_angle, measured_angle, output ready);
endinterface

interface ypid_out_if import ypid_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [RPM_W-1:0]   drive_rpm;
    logic                      in_position;
    logic                      clamped;

    modport source (output valid, drive_rpm, in_position, clamped, input ready);
    modport sink   (input valid, drive_rpm, in_position, clamped, output ready);
endinterface

>>> rtl/core/ypid_regs.sv
// ----------------------------------------------------------------------------
// ypid_regs
// APB-style configuration registers of the yaw PID controller.
// ----------------------------------------------------------------------------
module ypid_regs
    import ypid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PROP_GAIN:     cfg_next.prop_gain         = pwdata[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: cfg_next.integral_gain     = pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:    cfg_next.deriv_gain        = pwdata[GAIN_W-1:0];
                REG_OUTPUT_LOW:    cfg_next.output_low        = pwdata[LIMIT_W-1:0];
                REG_OUTPUT_HIGH:   cfg_next.output_high       = pwdata[LIMIT_W-1:0];
                REG_INTEG_BAND:    cfg_next.integration_band  = pwdata[BAND_W-1:0];
                REG_ARRIVAL_TOL:   cfg_next.arrival_tolerance = pwdata[BAND_W-1:0];
                REG_ARRIVAL_DEAD:  cfg_next.arrival_deadband  = pwdata[DEAD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain         <= '0;
            cfg_reg.integral_gain     <= '0;
            cfg_reg.deriv_gain        <= '0;
            cfg_reg.output_low        <= OUTPUT_LOW_RST;
            cfg_reg.output_high       <= OUTPUT_HIGH_RST;
            cfg_reg.integration_band  <= INTEG_BAND_RST;
            cfg_reg.arrival_tolerance <= ARRIVAL_TOL_RST;
            cfg_reg.arrival_deadband  <= ARRIVAL_DEAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PROP_GAIN:     prdata = PDATA_W'(cfg_reg.prop_gain);
            REG_INTEGRAL_GAIN: prdata = PDATA_W'(cfg_reg.integral_gain);
            REG_DERIV_GAIN:    prdata = PDATA_W'(cfg_reg.deriv_gain);
            REG_OUTPUT_LOW:    prdata = PDATA_W'($unsigned(cfg_reg.output_low));
            REG_OUTPUT_HIGH:   prdata = PDATA_W'($unsigned(cfg_reg.output_high));
            REG_INTEG_BAND:    prdata = PDATA_W'(cfg_reg.integration_band);
            REG_ARRIVAL_TOL:   prdata = PDATA_W'(cfg_reg.arrival_tolerance);
            REG_ARRIVAL_DEAD:  prdata = PDATA_W'(cfg_reg.arrival_deadband);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/ypid_ctrl.sv
// ----------------------------------------------------------------------------
// ypid_ctrl
// Sequencer of the yaw PID controller: steps the datapath through wrap,
// integration, digit-serial multiply, clamp, back-calculation divide and
// result write; the divide runs only when needed and run low skips to the write.
// ----------------------------------------------------------------------------
module ypid_ctrl
    import ypid_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WRAP   = 4'd1;
    localparam logic [3:0] S_INTEG  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_CLAMP  = 4'd4;
    localparam logic [3:0] S_EXCESS = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_BACK   = 4'd7;
    localparam logic [3:0] S_FINAL  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (sts.taken) state_next = S_WRAP;
            S_WRAP:   state_next = sts.run ? S_INTEG : S_FINAL;
            S_INTEG:  state_next = S_MUL;
            S_MUL:    if (sts.mul_last) state_next = S_CLAMP;
            S_CLAMP:  state_next = sts.need_div ? S_EXCESS : S_FINAL;
            S_EXCESS: state_next = S_DIV;
            S_DIV:    if (sts.div_last) state_next = S_BACK;
            S_BACK:   state_next = S_FINAL;
            S_FINAL:  if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd.idle   = (state_reg == S_IDLE);
        cmd.wrap   = (state_reg == S_WRAP);
        cmd.integ  = (state_reg == S_INTEG);
        cmd.mul    = (state_reg == S_MUL);
        cmd.clamp  = (state_reg == S_CLAMP);
        cmd.excess = (state_reg == S_EXCESS);
        cmd.div    = (state_reg == S_DIV);
        cmd.back   = (state_reg == S_BACK);
        cmd.finish = (state_reg == S_FINAL);
    end

`ifndef SYNTHESIS
    a_final_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINAL && !sts.out_free |=> state_reg == S_FINAL)
        else $error("result write left before output slot was free");

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && sts.taken |=> state_reg == S_WRAP)
        else $error("accepted item did not start processing");

    a_no_div_skip: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLAMP && !sts.need_div |=> state_reg == S_FINAL)
        else $error("divide entered without back-calculation");
`endif

endmodule

>>> rtl/core/ypid_dp.sv
// ----------------------------------------------------------------------------
// ypid_dp
// Datapath of the yaw PID controller: error wrap, integral with separation,
// radix-16 multiply-accumulate, clamp, restoring divider for anti-windup and
// the output register.
// ----------------------------------------------------------------------------
module ypid_dp
    import ypid_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = 32,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    ypid_in_if.sink    req,
    ypid_out_if.source rsp,
    input  cfg_t       cfg,
    input  cmd_t       cmd,
    output sts_t       sts
);

    localparam int IW = INTEGRAL_WIDTH;
    localparam int OW = IW + 1;
    localparam int PW = OW + DIGIT_W + 1;
    localparam int AW = IW + 20;
    localparam int EW = AW + 1;
    localparam int CW = $clog2(EW + 1);

    localparam logic signed [IW-1:0] INTEG_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] INTEG_MIN = {1'b1, {(IW-1){1'b0}}};

    logic                        run_reg, run_next;
    logic signed [DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [ERR_W-1:0]     err_reg, err_next;
    logic [BAND_W-1:0]           aerr_reg, aerr_next;
    logic signed [ERR_W-1:0]     prev_err_reg, prev_err_next;
    logic signed [ERR_W-1:0]     derr_reg, derr_next;
    logic signed [IW-1:0]        integ_reg, integ_next;
    logic signed [AW-1:0]        acc_reg, acc_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic signed [LIMIT_W-1:0]   u_reg, u_next;
    logic signed [LIMIT_W-1:0]   limit_reg, limit_next;
    logic                        clamp_reg, clamp_next;
    logic                        neg_reg, neg_next;
    logic [EW-1:0]               num_reg, num_next;
    logic [GAIN_W-1:0]           rem_reg, rem_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [RPM_W-1:0]     drive_reg, drive_next;
    logic                        inpos_reg, inpos_next;
    logic                        clampf_reg, clampf_next;

    logic                        taken;
    logic                        out_free;
    logic signed [DIFF_W-1:0]    wrapped;
    logic [DIFF_W-1:0]           wrapped_abs;
    logic signed [OW-1:0]        isum;
    logic signed [IW-1:0]        isum_sat;
    logic [1:0]                  k;
    logic signed [OW-1:0]        op;
    logic [GAIN_W-1:0]           gain;
    logic [DIGIT_W-1:0]          digit;
    logic signed [PW-1:0]        part;
    logic signed [AW-1:0]        part_ext;
    logic signed [AW-1:0]        u_full;
    logic signed [AW-1:0]        hi_ext;
    logic signed [AW-1:0]        lo_ext;
    logic                        over;
    logic                        under;
    logic signed [EW-1:0]        excess;
    logic [GAIN_W:0]             trial;
    logic                        trial_ge;
    logic signed [EW:0]          quot;
    logic signed [EW+1:0]        bdiff;
    logic [EW-IW+2:0]            bdiff_top;
    logic signed [IW-1:0]        bdiff_sat;
    logic signed [LIMIT_W-1:0]   u_round;
    logic [LIMIT_W-1:0]          u_abs;
    logic                        arrived;

    assign taken    = cmd.idle && req.valid;
    assign out_free = !out_valid_reg || rsp.ready;

    // shortest-path wrap, the difference spans at most two turns
    always_comb
    begin
        priority if (diff_reg > THREE_HALF_TURN)
            wrapped = diff_reg - TWO_TURNS;
        else if (diff_reg > HALF_TURN)
            wrapped = diff_reg - FULL_TURN;
        else if (diff_reg < -THREE_HALF_TURN)
            wrapped = diff_reg + TWO_TURNS;
        else if (diff_reg < -HALF_TURN)
            wrapped = diff_reg + FULL_TURN;
        else
            wrapped = diff_reg;
    end
    assign wrapped_abs = wrapped[DIFF_W-1] ? $unsigned(-wrapped) : $unsigned(wrapped);

    assign isum     = OW'(integ_reg) + OW'(err_reg);
    assign isum_sat = (isum[OW-1] != isum[OW-2]) ? (isum[OW-1] ? INTEG_MIN : INTEG_MAX)
                                                 : isum[IW-1:0];

    // multiply step: one 4-bit gain digit times one operand per cycle
    assign k = cnt_reg[1:0];
    always_comb
    begin
        unique case (cnt_reg[3:2])
            2'd0:
            begin
                op   = OW'(err_reg);
                gain = cfg.prop_gain;
            end
            2'd1:
            begin
                op   = OW'(integ_reg);
                gain = cfg.integral_gain;
            end
            default:
            begin
                op   = OW'(derr_reg);
                gain = cfg.deriv_gain;
            end
        endcase
    end
    assign digit    = gain[{k, 2'b00} +: DIGIT_W];
    assign part     = $signed({1'b0, digit}) * op;
    assign part_ext = AW'(part);

    assign u_full = acc_reg >>> GAIN_FRAC_BITS;
    assign hi_ext = AW'($signed(cfg.output_high));
    assign lo_ext = AW'($signed(cfg.output_low));
    assign over   = u_full > hi_ext;
    assign under  = u_full < lo_ext;

    assign excess = EW'(acc_reg) - (EW'(limit_reg) <<< GAIN_FRAC_BITS);

    assign trial    = {rem_reg, num_reg[EW-1]};
    assign trial_ge = trial >= {1'b0, cfg.integral_gain};

    assign quot      = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
    assign bdiff     = (EW+2)'(integ_reg) - (EW+2)'(quot);
    assign bdiff_top = bdiff[EW+1:IW-1];
    assign bdiff_sat = (&bdiff_top || ~|bdiff_top) ? bdiff[IW-1:0]
                     : (bdiff[EW+1] ? INTEG_MIN : INTEG_MAX);

    // truncate toward zero when dropping the 1/256 rpm fraction
    assign u_round = u_reg[LIMIT_W-1] ? u_reg + RPM_ROUND : u_reg;
    assign u_abs   = u_reg[LIMIT_W-1] ? $unsigned(-u_reg) : $unsigned(u_reg);
    assign arrived = (aerr_reg <= cfg.arrival_tolerance) && (u_abs < {1'b0, cfg.arrival_deadband});

    always_comb
    begin
        run_next       = run_reg;
        diff_next      = diff_reg;
        err_next       = err_reg;
        aerr_next      = aerr_reg;
        prev_err_next  = prev_err_reg;
        derr_next      = derr_reg;
        integ_next     = integ_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        u_next         = u_reg;
        limit_next     = limit_reg;
        clamp_next     = clamp_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        drive_next     = drive_reg;
        inpos_next     = inpos_reg;
        clampf_next    = clampf_reg;

        if (taken)
        begin
            run_next  = req.run;
            diff_next = DIFF_W'(req.target_angle) - DIFF_W'(req.measured_angle);
        end

        if (cmd.wrap)
        begin
            if (run_reg)
            begin
                err_next  = wrapped[ERR_W-1:0];
                aerr_next = wrapped_abs[BAND_W-1:0];
            end
            else
            begin
                integ_next    = '0;
                prev_err_next = '0;
            end
        end

        if (cmd.integ)
        begin
            integ_next    = (aerr_reg <= cfg.integration_band) ? isum_sat : '0;
            derr_next     = err_reg - prev_err_reg;
            prev_err_next = err_reg;
            acc_next      = '0;
            cnt_next      = '0;
        end

        if (cmd.mul)
        begin
            acc_next = acc_reg + (part_ext <<< {k, 2'b00});
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.clamp)
        begin
            clamp_next = over || under;
            limit_next = over ? cfg.output_high : cfg.output_low;
            priority if (over)
                u_next = cfg.output_high;
            else if (under)
                u_next = cfg.output_low;
            else
                u_next = u_full[LIMIT_W-1:0];
        end

        if (cmd.excess)
        begin
            neg_next = excess[EW-1];
            num_next = excess[EW-1] ? $unsigned(-excess) : $unsigned(excess);
            rem_next = '0;
            cnt_next = '0;
        end

        // restoring divide, one quotient bit per cycle
        if (cmd.div)
        begin
            rem_next = trial_ge ? GAIN_W'(trial - {1'b0, cfg.integral_gain})
                                : trial[GAIN_W-1:0];
            num_next = {num_reg[EW-2:0], trial_ge};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.back)
            integ_next = bdiff_sat;

        if (cmd.finish && out_free)
        begin
            out_valid_next = 1'b1;
            drive_next     = (run_reg && !arrived) ? u_round[LIMIT_W-1 -: RPM_W] : '0;
            inpos_next     = run_reg && arrived;
            clampf_next    = run_reg && clamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg    <= run_next;
        diff_reg   <= diff_next;
        err_reg    <= err_next;
        aerr_reg   <= aerr_next;
        derr_reg   <= derr_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        u_reg      <= u_next;
        limit_reg  <= limit_next;
        clamp_reg  <= clamp_next;
        neg_reg    <= neg_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        drive_reg  <= drive_next;
        inpos_reg  <= inpos_next;
        clampf_reg <= clampf_next;
    end

    assign req.ready       = cmd.idle;
    assign rsp.valid       = out_valid_reg;
    assign rsp.drive_rpm   = drive_reg;
    assign rsp.in_position = inpos_reg;
    assign rsp.clamped     = clampf_reg;

    always_comb
    begin
        sts.taken    = taken;
        sts.run      = run_reg;
        sts.mul_last = (cnt_reg == CW'(MUL_STEPS - 1));
        sts.need_div = (over || under) && (cfg.integral_gain != '0) && (integ_reg != '0);
        sts.div_last = (cnt_reg == CW'(EW - 1));
        sts.out_free = out_free;
    end

`ifndef SYNTHESIS
    a_arrival_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.in_position |-> rsp.drive_rpm == '0)
        else $error("in-position result with nonzero drive");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div |-> cnt_reg < CW'(EW))
        else $error("divider ran past its quotient width");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        taken |=> !req.ready)
        else $error("second item taken while one is in work");
`endif

endmodule

>>> rtl/core/yaw_pid_controller.sv
// ----------------------------------------------------------------------------
// yaw_pid_controller
// Heading-hold PID: wrapped heading error, integral separation, output clamp
// with back-calculation anti-windup and an arrival test.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one control tick per item (run, target_angle, measured_angle);
//   rsp returns one item per tick (drive_rpm, in_position, clamped). Gains,
//   clamps, band and arrival limits sit behind the APB port, written while idle.
//   One item at a time: a new tick is accepted only after the result of the
//   last one is written to the output register. A normal tick runs the
//   radix-16 multiply (12 steps, one 4-bit gain digit each); back-calculation
//   adds a restoring divider that yields one quotient bit per cycle over
//   INTEGRAL_WIDTH + 21 bits; with run low it skips to the write.
//   A finished result waits in the output register; the next item is accepted
//   meanwhile and its result is held back until the register is taken.
//   Reset clears integral and previous error, empties the output, loads defaults.
// ----------------------------------------------------------------------------
module yaw_pid_controller
    import ypid_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = 32,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    ypid_in_if.sink            req,
    ypid_out_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;

    ypid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ypid_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ypid_dp #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
